FILE: sv/mp2d_pkg.sv
// Shared types, constants and microcode definitions for the 2-D max pooling block.
package mp2d_pkg;

  // Build-time geometry.
  localparam int MAX_HEIGHT  = 64;
  localparam int MAX_WIDTH   = 64;
  localparam int ROW_STEP    = 1;
  localparam int COL_STEP    = 1;
  localparam int ROW_SPACING = 1;
  localparam int COL_SPACING = 1;
  localparam int OUT_LIMIT   = 64;

  // Field widths fixed by the register map and the item formats.
  localparam int SAMPLE_W   = 16;
  localparam int DIM_W      = 7;
  localparam int KER_W      = 5;
  localparam int PAD_W      = 4;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 8;

  // Derived widths.
  localparam int DEPTH   = MAX_HEIGHT * MAX_WIDTH;
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int ROW_W   = $clog2(MAX_HEIGHT + 1);
  localparam int COL_W   = $clog2(MAX_WIDTH + 1);
  localparam int OUT_W   = $clog2(OUT_LIMIT);
  localparam int PROD_W  = 2 * DIM_W;
  localparam int KER_MAX = (1 << KER_W) - 1;
  // Signed tap coordinate: covers the farthest tap of the farthest output plus a sign bit.
  localparam int TAP_W = $clog2((OUT_LIMIT - 1) * ROW_STEP + KER_MAX * ROW_SPACING
                                + (OUT_LIMIT - 1) * COL_STEP + KER_MAX * COL_SPACING + 1) + 1;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  // Input item kinds.
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_POOL = 1'b1;

  // Configuration register indexes.
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_IN_HEIGHT     = 4'd0;
  localparam cfg_idx_t REG_IN_WIDTH      = 4'd1;
  localparam cfg_idx_t REG_OUT_HEIGHT    = 4'd2;
  localparam cfg_idx_t REG_OUT_WIDTH     = 4'd3;
  localparam cfg_idx_t REG_KERNEL_HEIGHT = 4'd4;
  localparam cfg_idx_t REG_KERNEL_WIDTH  = 4'd5;
  localparam cfg_idx_t REG_PAD_TOP       = 4'd6;
  localparam cfg_idx_t REG_LEFT_PAD      = 4'd7;

  typedef struct packed {
    logic                       kind;
    logic signed [SAMPLE_W-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] max_value;
    logic                       empty_res;
    logic                       last;
  } out_item_t;

  // Microprogram steps.
  typedef enum logic [2:0] {
    ST_IDLE     = 3'd0,
    ST_INIT     = 3'd1,
    ST_ROW      = 3'd2,
    ST_TAP      = 3'd3,
    ST_ROW_NEXT = 3'd4,
    ST_EMIT     = 3'd5
  } step_t;

  // Condition that keeps the step counter where it is.
  typedef enum logic [1:0] {
    H_NONE     = 2'd0,
    H_NO_REQ   = 2'd1,
    H_OUT_BUSY = 2'd2
  } hold_t;

  // Condition that takes the jump to the target step.
  typedef enum logic [2:0] {
    J_NEVER    = 3'd0,
    J_ALWAYS   = 3'd1,
    J_KH_ZERO  = 3'd2,
    J_ROW_SKIP = 3'd3,
    J_KW_MORE  = 3'd4,
    J_KH_MORE  = 3'd5
  } jmp_t;

  typedef struct packed {
    hold_t hold_sel;
    jmp_t  jmp_sel;
    step_t target;
    logic  accept;
    logic  init;
    logic  row_start;
    logic  tap;
    logic  row_next;
    logic  emit;
  } ctrl_t;

  typedef struct packed {
    logic no_req;
    logic out_busy;
    logic kh_zero;
    logic row_skip;
    logic kw_more;
    logic kh_more;
  } cond_t;

  localparam ctrl_t CTRL_NOP = '{
    hold_sel:  H_NONE,
    jmp_sel:   J_NEVER,
    target:    ST_IDLE,
    accept:    1'b0,
    init:      1'b0,
    row_start: 1'b0,
    tap:       1'b0,
    row_next:  1'b0,
    emit:      1'b0
  };

  function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] v, int hi);
    if (v == '0) return DIM_W'(1);
    if (int'(v) > hi) return DIM_W'(hi);
    return v;
  endfunction

endpackage

FILE: sv/mp2d_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mp2d_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/mp2d_seq.sv
// Microcode sequencer: step counter, control store and jump logic.
module mp2d_seq (
  input  logic            clk,
  input  logic            rst,
  input  mp2d_pkg::cond_t cond,
  output mp2d_pkg::ctrl_t ctrl
);
  import mp2d_pkg::*;

  step_t pc;
  step_t pc_next;
  logic  hold_hit;
  logic  jmp_hit;

  // Control store: one word per step.
  always_comb begin
    ctrl = CTRL_NOP;
    unique case (pc)
      ST_IDLE: begin
        ctrl.accept   = 1'b1;
        ctrl.hold_sel = H_NO_REQ;
      end
      ST_INIT: begin
        ctrl.init    = 1'b1;
        ctrl.jmp_sel = J_KH_ZERO;
        ctrl.target  = ST_EMIT;
      end
      ST_ROW: begin
        ctrl.row_start = 1'b1;
        ctrl.jmp_sel   = J_ROW_SKIP;
        ctrl.target    = ST_ROW_NEXT;
      end
      ST_TAP: begin
        ctrl.tap     = 1'b1;
        ctrl.jmp_sel = J_KW_MORE;
        ctrl.target  = ST_TAP;
      end
      ST_ROW_NEXT: begin
        ctrl.row_next = 1'b1;
        ctrl.jmp_sel  = J_KH_MORE;
        ctrl.target   = ST_ROW;
      end
      ST_EMIT: begin
        ctrl.emit     = 1'b1;
        ctrl.hold_sel = H_OUT_BUSY;
        ctrl.jmp_sel  = J_ALWAYS;
        ctrl.target   = ST_IDLE;
      end
      default: begin
        ctrl.jmp_sel = J_ALWAYS;
        ctrl.target  = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    unique case (ctrl.hold_sel)
      H_NO_REQ:   hold_hit = cond.no_req;
      H_OUT_BUSY: hold_hit = cond.out_busy;
      default:    hold_hit = 1'b0;
    endcase

    unique case (ctrl.jmp_sel)
      J_ALWAYS:   jmp_hit = 1'b1;
      J_KH_ZERO:  jmp_hit = cond.kh_zero;
      J_ROW_SKIP: jmp_hit = cond.row_skip;
      J_KW_MORE:  jmp_hit = cond.kw_more;
      J_KH_MORE:  jmp_hit = cond.kh_more;
      default:    jmp_hit = 1'b0;
    endcase

    if (hold_hit) begin
      pc_next = pc;
    end else if (jmp_hit) begin
      pc_next = ctrl.target;
    end else begin
      pc_next = step_t'(3'(pc + 3'd1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= ST_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

FILE: sv/max_pool_2d.sv
// Top level of the 2-D max pooling block: registers, plane store and tap datapath.
//
// Usage: program the eight geometry registers over the cfg channel (always ready) while
// the block is idle. Input items with kind 0 load one sample each into the plane store in
// raster order; input items with kind 1 each request the next pooled output in raster
// order and produce one result item carrying the window maximum, an empty flag and a
// last flag on the final output of the plane.
// A load is written into the plane store as it is accepted. A request runs on the
// microcode sequencer, which reads one tap per cycle through the single read port of
// the plane store: each kernel row inside the plane reads its taps in turn, and a row
// outside the plane is skipped without a read.
// The result appears in the output register the cycle after the emit step.
// Reset returns the registers to their defaults (sizes 1, pads 0) and the load and output
// positions to zero; the plane store is not cleared by reset.
// When the receiver stalls, the result waits in the output register; loads are still
// taken, and the next request runs up to its emit step and waits there.
module max_pool_2d (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  mp2d_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output mp2d_pkg::out_item_t                 out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mp2d_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mp2d_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import mp2d_pkg::*;

  // Configuration registers; the input and output sizes are stored already clamped.
  logic [DIM_W-1:0] in_height;
  logic [DIM_W-1:0] in_width;
  logic [DIM_W-1:0] out_height;
  logic [DIM_W-1:0] out_width;
  logic [KER_W-1:0] kernel_height;
  logic [KER_W-1:0] kernel_width;
  logic [PAD_W-1:0] pad_top;
  logic [PAD_W-1:0] left_pad;

  logic [ADDR_W-1:0] load_position;
  logic [ADDR_W-1:0] load_position_next;
  logic [OUT_W-1:0]  out_row;
  logic [OUT_W-1:0]  out_col;

  logic signed [TAP_W-1:0]    h;
  logic signed [TAP_W-1:0]    w;
  logic [KER_W-1:0]           kh;
  logic [KER_W-1:0]           kw;
  logic [ADDR_W-1:0]          row_base;
  logic signed [SAMPLE_W-1:0] best;
  logic                       any_hit;
  logic                       rd_valid;

  ctrl_t ctrl;
  cond_t cond;

  logic                       load_fire;
  logic                       req_fire;
  logic                       emit_fire;
  logic [PROD_W-1:0]          plane_prod;
  logic [ADDR_W-1:0]          load_addr;
  logic [PROD_W-1:0]          load_inc;
  logic [PROD_W-1:0]          row_prod;
  logic                       h_in;
  logic                       w_in;
  logic [ADDR_W-1:0]          tap_addr;
  logic signed [SAMPLE_W-1:0] rdata;
  logic                       last_col;
  logic                       last_row;

  assign cfg_ready = 1'b1;
  assign in_ready  = ctrl.accept;
  assign load_fire = in_valid && in_ready && (in_data.kind == KIND_LOAD);
  assign req_fire  = in_valid && in_ready && (in_data.kind == KIND_POOL);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_height     <= DIM_W'(1);
      in_width      <= DIM_W'(1);
      out_height    <= DIM_W'(1);
      out_width     <= DIM_W'(1);
      kernel_height <= KER_W'(1);
      kernel_width  <= KER_W'(1);
      pad_top       <= '0;
      left_pad      <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_IN_HEIGHT:     in_height     <= clamp_dim(cfg_data[DIM_W-1:0], MAX_HEIGHT);
        REG_IN_WIDTH:      in_width      <= clamp_dim(cfg_data[DIM_W-1:0], MAX_WIDTH);
        REG_OUT_HEIGHT:    out_height    <= clamp_dim(cfg_data[DIM_W-1:0], OUT_LIMIT);
        REG_OUT_WIDTH:     out_width     <= clamp_dim(cfg_data[DIM_W-1:0], OUT_LIMIT);
        REG_KERNEL_HEIGHT: kernel_height <= cfg_data[KER_W-1:0];
        REG_KERNEL_WIDTH:  kernel_width  <= cfg_data[KER_W-1:0];
        REG_PAD_TOP:       pad_top       <= cfg_data[PAD_W-1:0];
        REG_LEFT_PAD:      left_pad      <= cfg_data[PAD_W-1:0];
        default: ;
      endcase
    end
  end

  // Loading: a position left beyond the plane by a size change restarts at zero.
  assign plane_prod = PROD_W'(in_height) * PROD_W'(in_width);
  assign load_addr  = (PROD_W'(load_position) >= plane_prod) ? '0 : load_position;
  assign load_inc   = PROD_W'(load_addr) + PROD_W'(1);
  assign load_position_next = (load_inc >= plane_prod) ? '0 : load_inc[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      load_position <= '0;
    end else if (load_fire) begin
      load_position <= load_position_next;
    end
  end

  // Tap bounds and addressing.
  assign h_in     = !h[TAP_W-1] && ($unsigned(h) < TAP_W'(in_height));
  assign w_in     = !w[TAP_W-1] && ($unsigned(w) < TAP_W'(in_width));
  assign row_prod = PROD_W'(h[ROW_W-1:0]) * PROD_W'(in_width);
  assign tap_addr = row_base + ADDR_W'(w[COL_W-1:0]);

  mp2d_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (DEPTH)
  ) u_plane_ram (
    .clk   (clk),
    .we    (load_fire),
    .waddr (load_addr),
    .wdata (in_data.sample),
    .re    (ctrl.tap && w_in),
    .raddr (tap_addr),
    .rdata (rdata)
  );

  always_comb begin
    cond.no_req   = !(in_valid && (in_data.kind == KIND_POOL));
    cond.out_busy = out_valid && !out_ready;
    cond.kh_zero  = (kernel_height == '0);
    cond.row_skip = !h_in || (kernel_width == '0);
    cond.kw_more  = ((KER_W+1)'(kw) + (KER_W+1)'(1)) < (KER_W+1)'(kernel_width);
    cond.kh_more  = ((KER_W+1)'(kh) + (KER_W+1)'(1)) < (KER_W+1)'(kernel_height);
  end

  mp2d_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .cond (cond),
    .ctrl (ctrl)
  );

  // Window walk. Read data arrives in the cycle after its tap step and is folded into best.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
      any_hit  <= 1'b0;
      best     <= SAMPLE_MIN;
    end else begin
      rd_valid <= ctrl.tap && w_in;
      if (ctrl.init) begin
        any_hit <= 1'b0;
        best    <= SAMPLE_MIN;
      end else if (rd_valid) begin
        any_hit <= 1'b1;
        if (!any_hit || (rdata > best)) begin
          best <= rdata;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.init) begin
      kh <= '0;
      h  <= TAP_W'(TAP_W'(out_row) * TAP_W'(ROW_STEP) - TAP_W'(pad_top));
    end else if (ctrl.row_next) begin
      kh <= kh + KER_W'(1);
      h  <= h + TAP_W'(ROW_SPACING);
    end
    if (ctrl.row_start) begin
      kw       <= '0;
      w        <= TAP_W'(TAP_W'(out_col) * TAP_W'(COL_STEP) - TAP_W'(left_pad));
      row_base <= row_prod[ADDR_W-1:0];
    end else if (ctrl.tap) begin
      kw <= kw + KER_W'(1);
      w  <= w + TAP_W'(COL_SPACING);
    end
  end

  // Result and output position. A position beyond the output size counts as the last.
  assign emit_fire = ctrl.emit && !cond.out_busy;
  assign last_col  = (DIM_W'(out_col) + DIM_W'(1)) >= out_width;
  assign last_row  = (DIM_W'(out_row) + DIM_W'(1)) >= out_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      out_row   <= '0;
      out_col   <= '0;
    end else if (emit_fire) begin
      out_valid <= 1'b1;
      if (last_col) begin
        out_col <= '0;
        out_row <= last_row ? '0 : out_row + OUT_W'(1);
      end else begin
        out_col <= out_col + OUT_W'(1);
      end
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_data.max_value <= best;
      out_data.empty_res <= !any_hit;
      out_data.last      <= last_col && last_row;
    end
  end

  // Read data is only folded in the cycle after a tap step.
  assert property (@(posedge clk) disable iff (rst) rd_valid |-> $past(ctrl.tap))
    else $error("read data valid without a preceding tap step");

  // An empty window always reports the most negative sample.
  assert property (@(posedge clk) disable iff (rst) !any_hit |-> best == SAMPLE_MIN)
    else $error("maximum moved away from its floor with no tap taken");

  // A request takes the sequencer out of its accepting step.
  assert property (@(posedge clk) disable iff (rst) req_fire |=> !in_ready)
    else $error("input still ready after a request was accepted");

  // The final output of the plane returns the output position to the origin.
  assert property (@(posedge clk) disable iff (rst)
    emit_fire && last_col && last_row |=> out_row == '0 && out_col == '0)
    else $error("output position did not wrap after the last output");

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the max_pool_2d block: stimulus, prediction and result checking.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import mp2d_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 12;
  localparam int RANDOM_ITEMS   = 500;
  localparam int LONG_HOLD      = 400;
  localparam int TALL_COLS      = 3;

  typedef struct packed {
    logic [DIM_W-1:0] in_h;
    logic [DIM_W-1:0] in_w;
    logic [DIM_W-1:0] out_h;
    logic [DIM_W-1:0] out_w;
    logic [KER_W-1:0] ker_h;
    logic [KER_W-1:0] ker_w;
    logic [PAD_W-1:0] pad_t;
    logic [PAD_W-1:0] pad_l;
  } geom_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  cfg_idx_t              cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Predictor state.
  geom_t geom = '{in_h: DIM_W'(1), in_w: DIM_W'(1), out_h: DIM_W'(1), out_w: DIM_W'(1),
                  ker_h: KER_W'(1), ker_w: KER_W'(1), pad_t: '0, pad_l: '0};
  logic signed [SAMPLE_W-1:0] plane_mem [DEPTH];
  bit                         plane_written [DEPTH];
  int                         load_ptr = 0;
  int                         out_r = 0;
  int                         out_c = 0;
  out_item_t                  pooled_q [$];

  int        fail_count = 0;
  int        quiet_cycles = 0;
  int        burst_left = 0;
  bit        steady_sender = 1'b0;
  int        rx_hold = 0;
  int        rx_left = 0;
  logic [15:0] rx_pattern = '1;
  out_item_t want;

  max_pool_2d dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  function automatic int sat_dim(input logic [DIM_W-1:0] v, input int hi);
    if (v == '0) return 1;
    if (int'(v) > hi) return hi;
    return int'(v);
  endfunction

  // Walks the window of the next output. Returns 0 if any in-plane tap hits an
  // entry that was never loaded, so the caller can avoid reading it.
  function automatic bit walk_window(output out_item_t res);
    int ih, iw, oh, ow, r, c, addr;
    bit all_loaded, hit;
    logic signed [SAMPLE_W-1:0] best;
    ih = sat_dim(geom.in_h, MAX_HEIGHT);
    iw = sat_dim(geom.in_w, MAX_WIDTH);
    oh = sat_dim(geom.out_h, OUT_LIMIT);
    ow = sat_dim(geom.out_w, OUT_LIMIT);
    all_loaded = 1'b1;
    hit = 1'b0;
    best = SAMPLE_MIN;
    for (int kh = 0; kh < int'(geom.ker_h); kh++) begin
      r = out_r * ROW_STEP + kh * ROW_SPACING - int'(geom.pad_t);
      if (r < 0 || r >= ih) continue;
      for (int kw = 0; kw < int'(geom.ker_w); kw++) begin
        c = out_c * COL_STEP + kw * COL_SPACING - int'(geom.pad_l);
        if (c < 0 || c >= iw) continue;
        addr = r * iw + c;
        if (!plane_written[addr]) all_loaded = 1'b0;
        if (!hit || plane_mem[addr] > best) best = plane_mem[addr];
        hit = 1'b1;
      end
    end
    res.max_value = best;
    res.empty_res = !hit;
    res.last = (out_c + 1 >= ow) && (out_r + 1 >= oh);
    return all_loaded;
  endfunction

  function automatic void predict_item(input in_item_t item);
    out_item_t res;
    int plane_sz, oh, ow;
    if (item.kind == KIND_LOAD) begin
      plane_sz = sat_dim(geom.in_h, MAX_HEIGHT) * sat_dim(geom.in_w, MAX_WIDTH);
      if (load_ptr >= plane_sz) load_ptr = 0;
      plane_mem[load_ptr] = item.sample;
      plane_written[load_ptr] = 1'b1;
      load_ptr = (load_ptr + 1 >= plane_sz) ? 0 : load_ptr + 1;
    end else begin
      void'(walk_window(res));
      pooled_q.push_back(res);
      oh = sat_dim(geom.out_h, OUT_LIMIT);
      ow = sat_dim(geom.out_w, OUT_LIMIT);
      if (out_c + 1 >= ow) begin
        out_c = 0;
        out_r = (out_r + 1 >= oh) ? 0 : out_r + 1;
      end else begin
        out_c++;
      end
    end
  endfunction

  // Offers one item and returns at the edge that accepts it. The sender then
  // either keeps valid high for the next item or drops it for a random gap.
  task automatic send_item(input in_item_t item);
    int gap;
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_item(item);
    if (steady_sender) return;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
      if ($urandom_range(0, 15) == 0) gap = $urandom_range(10, 30);
      else if ($urandom_range(0, 2) == 0) gap = 0;
      else gap = $urandom_range(1, 5);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic load_sample(input logic signed [SAMPLE_W-1:0] s);
    in_item_t item;
    item.kind = KIND_LOAD;
    item.sample = s;
    send_item(item);
  endtask

  task automatic request_pool();
    in_item_t item;
    item.kind = KIND_POOL;
    item.sample = SAMPLE_W'($urandom);
    send_item(item);
  endtask

  // A request whose window would touch unloaded entries turns into a load.
  task automatic send_random(input bit want_pool);
    out_item_t unused;
    if (want_pool && walk_window(unused)) request_pool();
    else load_sample(SAMPLE_W'($urandom));
  endtask

  task automatic settle_block();
    in_valid <= 1'b0;
    while (pooled_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_IN_HEIGHT:     geom.in_h  = data[DIM_W-1:0];
      REG_IN_WIDTH:      geom.in_w  = data[DIM_W-1:0];
      REG_OUT_HEIGHT:    geom.out_h = data[DIM_W-1:0];
      REG_OUT_WIDTH:     geom.out_w = data[DIM_W-1:0];
      REG_KERNEL_HEIGHT: geom.ker_h = data[KER_W-1:0];
      REG_KERNEL_WIDTH:  geom.ker_w = data[KER_W-1:0];
      REG_PAD_TOP:       geom.pad_t = data[PAD_W-1:0];
      REG_LEFT_PAD:      geom.pad_l = data[PAD_W-1:0];
      default: ;
    endcase
  endtask

  task automatic program_geometry(input logic [CFG_DATA_W-1:0] ih, iw, oh, ow, kh, kw, pt, pl);
    settle_block();
    write_reg(REG_IN_HEIGHT, ih);
    write_reg(REG_IN_WIDTH, iw);
    write_reg(REG_OUT_HEIGHT, oh);
    write_reg(REG_OUT_WIDTH, ow);
    write_reg(REG_KERNEL_HEIGHT, kh);
    write_reg(REG_KERNEL_WIDTH, kw);
    write_reg(REG_PAD_TOP, pt);
    write_reg(REG_LEFT_PAD, pl);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_dim();
    case ($urandom_range(0, 9))
      0: return 8'd0;
      1: return 8'd64;
      2: return 8'($urandom_range(65, 255));
      default: return 8'($urandom_range(1, 8));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_kernel();
    case ($urandom_range(0, 11))
      0: return 8'd0;
      1: return 8'd16;
      2: return 8'($urandom_range(17, 255));
      default: return 8'($urandom_range(1, 4));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_pad();
    if ($urandom_range(0, 3) == 0) return 8'($urandom);
    return 8'($urandom_range(0, 2));
  endfunction

  // Registers hold their reset values here.
  task automatic test_reset_defaults();
    load_sample(16'sh7FFF);
    request_pool();
    load_sample(16'sh8000);
    request_pool();
  endtask

  task automatic test_extreme_samples();
    program_geometry(8'd3, 8'd3, 8'd2, 8'd2, 8'd2, 8'd2, 8'd0, 8'd0);
    load_sample(16'sh7FFF);
    load_sample(16'sh8000);
    load_sample(-16'sd1);
    load_sample(16'sd0);
    load_sample(16'sd1);
    load_sample(16'sh5555);
    load_sample(16'shAAAA);
    load_sample(-16'sd2);
    load_sample(16'sd2);
    repeat (4) request_pool();
  endtask

  task automatic test_empty_windows();
    // Padding pushes the whole window above the plane.
    program_geometry(8'd3, 8'd3, 8'd1, 8'd2, 8'd1, 8'd1, 8'd15, 8'd0);
    repeat (2) request_pool();
    // A zero-width kernel has no taps at all.
    program_geometry(8'd3, 8'd3, 8'd1, 8'd1, 8'd3, 8'd0, 8'd0, 8'd0);
    request_pool();
    // The largest kernel with the largest pads still covers the plane.
    program_geometry(8'd3, 8'd3, 8'd1, 8'd1, 8'd31, 8'd31, 8'd15, 8'd15);
    request_pool();
  endtask

  task automatic test_output_position_beyond();
    program_geometry(8'd3, 8'd3, 8'd2, 8'd4, 8'd1, 8'd1, 8'd0, 8'd0);
    repeat (2) request_pool();
    // The column left past the new width counts as the last one.
    program_geometry(8'd3, 8'd3, 8'd2, 8'd1, 8'd1, 8'd1, 8'd0, 8'd0);
    repeat (2) request_pool();
  endtask

  task automatic test_load_wrap();
    load_sample(SAMPLE_W'($urandom));
    load_sample(SAMPLE_W'($urandom));
    // Zero height saturates to one row, and an oversized output width to the limit;
    // the load position left beyond the shrunken plane restarts at zero.
    program_geometry(8'd0, 8'd1, 8'd0, 8'd200, 8'd1, 8'd1, 8'd0, 8'd0);
    load_sample(SAMPLE_W'($urandom));
    request_pool();
  endtask

  task automatic test_backpressure();
    program_geometry(8'd4, 8'd4, 8'd3, 8'd3, 8'd2, 8'd2, 8'd0, 8'd0);
    repeat (16) send_random(1'b0);
    steady_sender = 1'b1;
    rx_hold = LONG_HOLD;
    repeat (24) send_random($urandom_range(0, 3) != 0);
    steady_sender = 1'b0;
    // Sender waits here until every result has drained.
    settle_block();
    repeat (12) send_random(1'b1);
  endtask

  task automatic test_full_plane();
    program_geometry(8'd64, 8'd3, 8'd64, 8'd2, 8'd2, 8'd31, 8'd0, 8'd0);
    repeat (MAX_HEIGHT * TALL_COLS) send_random(1'b0);
    repeat (32) send_random(1'b1);
  endtask

  task automatic test_random_phases();
    int sent, plane_sz, n_loads, n_reqs, cap;
    logic [CFG_DATA_W-1:0] ih, iw;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      ih = pick_dim();
      iw = pick_dim();
      // Keep the plane small when one side is larger than 8.
      if (sat_dim(ih[DIM_W-1:0], MAX_HEIGHT) > 8) iw = 8'($urandom_range(1, 2));
      else if (sat_dim(iw[DIM_W-1:0], MAX_WIDTH) > 8) ih = 8'($urandom_range(1, 2));
      program_geometry(ih, iw, pick_dim(), pick_dim(), pick_kernel(), pick_kernel(),
                       pick_pad(), pick_pad());
      plane_sz = sat_dim(geom.in_h, MAX_HEIGHT) * sat_dim(geom.in_w, MAX_WIDTH);
      n_loads = ($urandom_range(0, 4) == 0) ? $urandom_range(0, plane_sz) : plane_sz;
      cap = sat_dim(geom.out_h, OUT_LIMIT) * sat_dim(geom.out_w, OUT_LIMIT) + 3;
      if (cap > 30) cap = 30;
      n_reqs = $urandom_range(1, cap);
      for (int k = 0; k < n_loads + n_reqs; k++) begin
        if (k < n_loads) send_random($urandom_range(0, 15) == 0);
        else send_random($urandom_range(0, 7) != 0);
      end
      sent += n_loads + n_reqs;
    end
  endtask

  // Receiver: ready follows a random pattern, redrawn whenever its run counter expires,
  // unless a long hold-off has been requested.
  always @(posedge clk) begin
    if (rx_hold > 0) begin
      rx_hold = rx_hold - 1;
      out_ready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom | $urandom);
        rx_left = 64;
      end
      rx_left = rx_left - 1;
      out_ready <= rx_pattern[rx_left % 16];
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pooled_q.size() == 0) begin
        $display("%0t: unexpected result item: max_value %0d empty_res %0b last %0b",
                 $time, out_data.max_value, out_data.empty_res, out_data.last);
        fail_count++;
      end else begin
        want = pooled_q.pop_front();
        if (out_data.max_value !== want.max_value) begin
          $display("%0t: max_value expected %0d, got %0d",
                   $time, want.max_value, out_data.max_value);
          fail_count++;
        end
        if (out_data.empty_res !== want.empty_res) begin
          $display("%0t: empty_res expected %0b, got %0b",
                   $time, want.empty_res, out_data.empty_res);
          fail_count++;
        end
        if (out_data.last !== want.last) begin
          $display("%0t: last expected %0b, got %0b", $time, want.last, out_data.last);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, quiet_cycles);
      $display("max_pool_2d verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_extreme_samples();
    test_empty_windows();
    test_output_position_beyond();
    test_load_wrap();
    test_backpressure();
    test_full_plane();
    test_random_phases();
    settle_block();
    if (fail_count == 0 && pooled_q.size() == 0) begin
      $display("max_pool_2d verification clean");
    end else begin
      $display("max_pool_2d verification failed");
    end
    $finish;
  end

endmodule

FILE: max_pool_2d.f
sv/mp2d_pkg.sv
sv/mp2d_ram.sv
sv/mp2d_seq.sv
sv/max_pool_2d.sv
tb/testbench.sv
